[design/tspq_pkg.sv]
// Shared types and codes for the three-level stable priority queue.
// No dependencies; used by every module of the block but tspq_ram.
package tspq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] LVL_LOW     = 2'd2;
    localparam logic [1:0] LVL_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] entry_id;
        logic [31:0] payload_handle;
        logic [1:0]  priority_level;
    } t_in_item;

    typedef struct packed {
        logic        head_valid;
        logic [15:0] head_id;
        logic [31:0] head_handle;
        logic [1:0]  head_level;
        logic [5:0]  entry_count;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] handle;
        logic [1:0]  level;
    } t_entry;

    typedef struct packed {
        logic load;
        logic pop;
        logic walk_start;
        logic rd_issue;
        logic proc;
        logic walk_end;
        logic append;
        logic head_rd;
        logic out_load;
        logic flag_full;
        logic flag_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       walk_done;
        logic       inserted;
        logic       ins_now;
    } t_dp_sts;

endpackage

[design/tspq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tspq_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/tspq_dp.sv]
// Datapath: circular entry store, head/count pointers, walk registers, result register.
// Depends on tspq_pkg and tspq_ram; driven by commands from tspq_ctrl.
module tspq_dp #(
    parameter int DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tspq_pkg::t_in_item  i_item,
    input  tspq_pkg::t_dp_cmd   i_cmd,
    output tspq_pkg::t_dp_sts   o_sts,
    output tspq_pkg::t_out_item o_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = CW + 6;
    localparam int DW = $bits(tspq_pkg::t_entry);

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_base, n_base;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_wcnt, n_wcnt;
    logic          r_ins, n_ins;
    logic [1:0]    r_op;
    logic [1:0]    r_status;
    tspq_pkg::t_entry    r_key;
    tspq_pkg::t_out_item r_out;

    logic [SW-1:0]    tail_sum;
    logic [AW-1:0]    tail;
    logic [DW-1:0]    rdata;
    tspq_pkg::t_entry rentry;
    logic             ins_now;
    logic             keep;
    logic             wr_en;
    logic [AW-1:0]    waddr;
    tspq_pkg::t_entry wentry;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [EW-1:0]    cnt_ext;
    logic [1:0]       in_level;

    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign rentry   = tspq_pkg::t_entry'(rdata);

    assign ins_now = (r_op == tspq_pkg::OP_INSERT) && !r_ins && (rentry.level > r_key.level);
    assign keep    = (r_op == tspq_pkg::OP_INSERT) || (rentry.id != r_key.id);

    assign wr_en  = i_cmd.append || (i_cmd.proc && (ins_now || keep));
    assign waddr  = i_cmd.append ? tail : r_wr;
    assign wentry = (i_cmd.append || ins_now) ? r_key : rentry;
    assign re     = i_cmd.rd_issue || i_cmd.head_rd;
    assign raddr  = i_cmd.head_rd ? r_head : r_rd;

    assign in_level = (i_item.priority_level == tspq_pkg::LVL_INVALID) ?
                      tspq_pkg::LVL_LOW : i_item.priority_level;
    assign cnt_ext  = EW'(r_count);

    tspq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (DW'(wentry)),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_rd    = r_rd;
        n_wr    = r_wr;
        n_base  = r_base;
        n_left  = r_left;
        n_wcnt  = r_wcnt;
        n_ins   = r_ins;
        if (i_cmd.pop) begin
            n_head  = f_inc(r_head);
            n_count = r_count - 1'b1;
        end
        if (i_cmd.walk_start) begin
            n_rd   = r_head;
            n_wr   = tail;
            n_base = tail;
            n_left = r_count;
            n_wcnt = '0;
            n_ins  = 1'b0;
        end
        if (i_cmd.rd_issue) begin
            n_rd   = f_inc(r_rd);
            n_left = r_left - 1'b1;
        end
        if (i_cmd.proc && (ins_now || keep)) begin
            n_wr   = f_inc(r_wr);
            n_wcnt = r_wcnt + 1'b1;
            if (ins_now) begin
                n_ins = 1'b1;
            end
        end
        if (i_cmd.walk_end) begin
            n_head  = r_base;
            n_count = r_wcnt;
        end
        if (i_cmd.append) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_wcnt  <= '0;
            r_ins   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_left  <= n_left;
            r_wcnt  <= n_wcnt;
            r_ins   <= n_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd   <= n_rd;
        r_wr   <= n_wr;
        r_base <= n_base;
        if (i_cmd.load) begin
            r_op         <= i_item.operation;
            r_key.id     <= i_item.entry_id;
            r_key.handle <= i_item.payload_handle;
            r_key.level  <= in_level;
            r_status     <= tspq_pkg::ST_DONE;
        end
        if (i_cmd.flag_full) begin
            r_status <= tspq_pkg::ST_FULL;
        end
        if (i_cmd.flag_empty) begin
            r_status <= tspq_pkg::ST_EMPTY;
        end
        if (i_cmd.out_load) begin
            r_out.head_valid  <= (r_count != '0);
            r_out.head_id     <= (r_count != '0) ? rentry.id : '0;
            r_out.head_handle <= (r_count != '0) ? rentry.handle : '0;
            r_out.head_level  <= (r_count != '0) ? rentry.level : '0;
            r_out.entry_count <= cnt_ext[5:0];
            r_out.status      <= r_status;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.full      = (r_count == CW'(DEPTH));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.walk_done = (r_left == '0);
    assign o_sts.inserted  = r_ins;
    assign o_sts.ins_now   = ins_now;
    assign o_item          = r_out;

endmodule

[design/tspq_ctrl.sv]
// Controller: sequences each queue command and runs the input and output handshakes.
// Depends on tspq_pkg; drives tspq_dp through a command struct.
module tspq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tspq_pkg::t_dp_sts i_sts,
    output tspq_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RD     = 3'd2;
    localparam logic [2:0] S_PROC   = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;
    localparam logic [2:0] S_HEAD   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    tspq_pkg::OP_INSERT, tspq_pkg::OP_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.flag_full = 1'b1;
                            n_state         = S_HEAD;
                        end else if (i_sts.op == tspq_pkg::OP_APPEND || i_sts.empty) begin
                            n_state = S_APPEND;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_RD;
                        end
                    end
                    tspq_pkg::OP_POP: begin
                        if (i_sts.empty) begin
                            o_cmd.flag_empty = 1'b1;
                        end else begin
                            o_cmd.pop = 1'b1;
                        end
                        n_state = S_HEAD;
                    end
                    default: begin
                        if (i_sts.empty) begin
                            n_state = S_HEAD;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_RD;
                        end
                    end
                endcase
            end
            S_RD: begin
                if (i_sts.walk_done) begin
                    o_cmd.walk_end = 1'b1;
                    if (i_sts.op == tspq_pkg::OP_INSERT && !i_sts.inserted) begin
                        n_state = S_APPEND;
                    end else begin
                        n_state = S_HEAD;
                    end
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_PROC;
                end
            end
            S_PROC: begin
                // new entry goes first; the read entry is written on the next pass
                o_cmd.proc = 1'b1;
                if (!i_sts.ins_now) begin
                    n_state = S_RD;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[design/three_level_stable_priority_queue.sv]
// Three-level stable priority queue: one item in, one result out, holding up to DEPTH
// entries in a circular RAM. Append, pop, remove on an empty store and the full/empty
// error cases need no walk. Priority insert and remove-by-id rotate every held entry
// once through the single-port-pair RAM (read, then write back), and insert also writes
// the new entry, mid-queue or at the tail; an insert into an empty store runs as a
// plain append. The result register lets the next item enter while the last result
// waits to be taken. No clearing pass is needed after reset.
// Depends on tspq_pkg, tspq_ctrl, tspq_dp and tspq_ram.
module three_level_stable_priority_queue #(
    parameter int DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tspq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tspq_pkg::t_out_item o_out_item
);

    tspq_pkg::t_dp_cmd dp_cmd;
    tspq_pkg::t_dp_sts dp_sts;

    tspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    tspq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_item  (o_out_item)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("controller took a second item before finishing the first");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without an item in progress");

    a_full_flag_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == tspq_pkg::ST_FULL) |->
        (DEPTH > 63 || o_out_item.entry_count == 6'(DEPTH)))
        else $error("insert dropped while store not full");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        (DEPTH > 63 || o_out_item.head_valid == (o_out_item.entry_count != 6'd0)))
        else $error("head valid disagrees with entry count");

endmodule

[verif/tb_three_level_stable_priority_queue.sv]
// Testbench for the three-level stable priority queue: a directed command table, then
// random phases, with every result checked against a typed row or the bench's queue predictor.
// Depends on tspq_pkg and three_level_stable_priority_queue.
module tb_three_level_stable_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 32;
    localparam int TOTAL_ITEMS  = 1950;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [1:0] LVL_HIGH = 2'd0;
    localparam logic [1:0] LVL_MID  = 2'd1;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_PURGE} t_phase;

    typedef struct packed {
        tspq_pkg::t_in_item  cmd;
        logic                typed;
        tspq_pkg::t_out_item result;
    } t_row;

    localparam tspq_pkg::t_out_item NO_RESULT = '0;
    localparam int ROWS = 25;
    localparam t_row DIRECTED [ROWS] = '{
        '{'{tspq_pkg::OP_POP,    16'h0000, 32'h0000_0000, LVL_HIGH}, 1'b1,
          '{1'b0, 16'h0000, 32'h0000_0000, LVL_HIGH, 6'd0, tspq_pkg::ST_EMPTY}},
        '{'{tspq_pkg::OP_REMOVE, 16'h0000, 32'h0000_0000, LVL_HIGH}, 1'b1,
          '{1'b0, 16'h0000, 32'h0000_0000, LVL_HIGH, 6'd0, tspq_pkg::ST_DONE}},
        '{'{tspq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, LVL_HIGH}, 1'b1,
          '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, LVL_HIGH, 6'd1, tspq_pkg::ST_DONE}},
        '{'{tspq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000, tspq_pkg::LVL_INVALID}, 1'b1,
          '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, LVL_HIGH, 6'd2, tspq_pkg::ST_DONE}},
        '{'{tspq_pkg::OP_INSERT, 16'h0001, 32'h1234_5678, LVL_MID}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_INSERT, 16'h0002, 32'h8765_4321, tspq_pkg::LVL_LOW}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_APPEND, 16'h0003, 32'hDEAD_BEEF, LVL_HIGH}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_INSERT, 16'h0004, 32'h0F0F_0F0F, LVL_HIGH}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_INSERT, 16'h0005, 32'hF0F0_F0F0, tspq_pkg::LVL_INVALID}, 1'b0,
          NO_RESULT},
        '{'{tspq_pkg::OP_APPEND, 16'h0006, 32'h5555_AAAA, tspq_pkg::LVL_INVALID}, 1'b0,
          NO_RESULT},
        '{'{tspq_pkg::OP_REMOVE, 16'h0003, 32'h0000_0000, LVL_HIGH}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_APPEND, 16'h0001, 32'hAAAA_5555, tspq_pkg::LVL_LOW}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_REMOVE, 16'h0001, 32'hFFFF_FFFF, tspq_pkg::LVL_INVALID}, 1'b0,
          NO_RESULT},
        '{'{tspq_pkg::OP_REMOVE, 16'hBEEF, 32'h0000_0000, LVL_HIGH}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_REMOVE, 16'hFFFF, 32'h0000_0000, LVL_HIGH}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_POP,    16'h0000, 32'h0000_0000, LVL_HIGH}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_POP,    16'hFFFF, 32'hFFFF_FFFF, tspq_pkg::LVL_INVALID}, 1'b0,
          NO_RESULT},
        '{'{tspq_pkg::OP_POP,    16'h0000, 32'h0000_0000, LVL_HIGH}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_POP,    16'h0000, 32'h0000_0000, LVL_HIGH}, 1'b0, NO_RESULT},
        '{'{tspq_pkg::OP_POP,    16'h0000, 32'h0000_0000, LVL_HIGH}, 1'b1,
          '{1'b0, 16'h0000, 32'h0000_0000, LVL_HIGH, 6'd0, tspq_pkg::ST_DONE}},
        '{'{tspq_pkg::OP_POP,    16'h0000, 32'h0000_0000, LVL_HIGH}, 1'b1,
          '{1'b0, 16'h0000, 32'h0000_0000, LVL_HIGH, 6'd0, tspq_pkg::ST_EMPTY}},
        '{'{tspq_pkg::OP_INSERT, 16'h8000, 32'hA5A5_A5A5, LVL_MID}, 1'b1,
          '{1'b1, 16'h8000, 32'hA5A5_A5A5, LVL_MID, 6'd1, tspq_pkg::ST_DONE}},
        '{'{tspq_pkg::OP_INSERT, 16'h7FFF, 32'h5A5A_5A5A, LVL_HIGH}, 1'b1,
          '{1'b1, 16'h7FFF, 32'h5A5A_5A5A, LVL_HIGH, 6'd2, tspq_pkg::ST_DONE}},
        '{'{tspq_pkg::OP_REMOVE, 16'h8000, 32'h0000_0000, LVL_HIGH}, 1'b1,
          '{1'b1, 16'h7FFF, 32'h5A5A_5A5A, LVL_HIGH, 6'd1, tspq_pkg::ST_DONE}},
        '{'{tspq_pkg::OP_REMOVE, 16'h7FFF, 32'h0000_0000, LVL_HIGH}, 1'b1,
          '{1'b0, 16'h0000, 32'h0000_0000, LVL_HIGH, 6'd0, tspq_pkg::ST_DONE}}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    tspq_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    tspq_pkg::t_out_item o_out_item;

    tspq_pkg::t_entry    queue_model[$];
    tspq_pkg::t_out_item pending_heads[$];
    tspq_pkg::t_out_item head_due;
    int        mismatches = 0;
    int        sink_wait = 0;
    bit        hold_req = 1'b0;
    bit        send_idle = 1'b1;
    bit        sink_idle = 1'b1;

    three_level_stable_priority_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic tspq_pkg::t_out_item apply_command(tspq_pkg::t_in_item cmd);
        tspq_pkg::t_entry    rebuilt[$];
        tspq_pkg::t_entry    fresh;
        tspq_pkg::t_out_item res;
        int                  pos;
        res = '0;
        res.status = tspq_pkg::ST_DONE;
        fresh.id = cmd.entry_id;
        fresh.handle = cmd.payload_handle;
        fresh.level = (cmd.priority_level == tspq_pkg::LVL_INVALID) ?
                      tspq_pkg::LVL_LOW : cmd.priority_level;
        case (cmd.operation)
            tspq_pkg::OP_INSERT, tspq_pkg::OP_APPEND: begin
                if (queue_model.size() >= DEPTH) begin
                    res.status = tspq_pkg::ST_FULL;
                end else begin
                    pos = queue_model.size();
                    if (cmd.operation == tspq_pkg::OP_INSERT) begin
                        for (int k = queue_model.size() - 1; k >= 0; k--) begin
                            if (queue_model[k].level > fresh.level) pos = k;
                        end
                    end
                    for (int k = 0; k < queue_model.size(); k++) begin
                        if (k == pos) rebuilt.push_back(fresh);
                        rebuilt.push_back(queue_model[k]);
                    end
                    if (pos == queue_model.size()) rebuilt.push_back(fresh);
                    queue_model = rebuilt;
                end
            end
            tspq_pkg::OP_POP: begin
                if (queue_model.size() == 0) begin
                    res.status = tspq_pkg::ST_EMPTY;
                end else begin
                    void'(queue_model.pop_front());
                end
            end
            default: begin
                foreach (queue_model[k]) begin
                    if (queue_model[k].id != cmd.entry_id) rebuilt.push_back(queue_model[k]);
                end
                queue_model = rebuilt;
            end
        endcase
        if (queue_model.size() > 0) begin
            res.head_valid = 1'b1;
            res.head_id = queue_model[0].id;
            res.head_handle = queue_model[0].handle;
            res.head_level = queue_model[0].level;
        end
        res.entry_count = 6'(queue_model.size());
        return res;
    endfunction

    function automatic tspq_pkg::t_in_item random_command(t_phase ph);
        tspq_pkg::t_in_item cmd;
        int                 roll;
        int                 id_span;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                cmd.operation = roll < 45 ? tspq_pkg::OP_INSERT :
                                roll < 80 ? tspq_pkg::OP_APPEND :
                                roll < 90 ? tspq_pkg::OP_POP : tspq_pkg::OP_REMOVE;
            PH_DRAIN:
                cmd.operation = roll < 15 ? tspq_pkg::OP_INSERT :
                                roll < 25 ? tspq_pkg::OP_APPEND :
                                roll < 85 ? tspq_pkg::OP_POP : tspq_pkg::OP_REMOVE;
            PH_MIXED:
                cmd.operation = roll < 30 ? tspq_pkg::OP_INSERT :
                                roll < 50 ? tspq_pkg::OP_APPEND :
                                roll < 80 ? tspq_pkg::OP_POP : tspq_pkg::OP_REMOVE;
            default:
                cmd.operation = roll < 30 ? tspq_pkg::OP_INSERT :
                                roll < 45 ? tspq_pkg::OP_APPEND :
                                roll < 60 ? tspq_pkg::OP_POP : tspq_pkg::OP_REMOVE;
        endcase
        // small id pool so removes find matches, with some full-range ids mixed in
        id_span = (ph == PH_PURGE) ? 5 : 11;
        cmd.entry_id = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, id_span));
        cmd.payload_handle = $urandom;
        cmd.priority_level = 2'($urandom_range(0, 3));
        return cmd;
    endfunction

    task automatic send_command(input tspq_pkg::t_in_item cmd, input logic typed,
                                input tspq_pkg::t_out_item typed_result);
        int                  gap;
        tspq_pkg::t_out_item predicted;
        gap = send_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_command(cmd);
        pending_heads.push_back(typed ? typed_result : predicted);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_heads.size() != 0);
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
            end
        end
    endtask

    initial begin : stimulus
        t_phase ph;
        int     sent;
        int     span;
        int     phase_no;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED[r]) begin
            send_command(DIRECTED[r].cmd, DIRECTED[r].typed, DIRECTED[r].result);
        end
        sent = ROWS;
        ph = PH_FILL;
        phase_no = 0;
        while (sent < TOTAL_ITEMS) begin
            settle();
            send_idle = (phase_no % 5 != 4);
            sink_idle = (phase_no % 5 != 4) && (phase_no % 3 != 1);
            if (phase_no == 2) hold_req = 1'b1;
            span = $urandom_range(90, 150);
            for (int n = 0; n < span && sent < TOTAL_ITEMS; n++) begin
                send_command(random_command(ph), 1'b0, NO_RESULT);
                sent++;
            end
            ph = t_phase'((int'(ph) + 1) % 4);
            phase_no++;
        end
        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_heads.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : result_sink
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                sink_wait = LONG_HOLD;
            end
            if (sink_wait > 0) begin
                i_out_ready <= 1'b0;
                sink_wait--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_heads.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result with nothing pending: %h", $time, o_out_item);
                end
            end else begin
                head_due = pending_heads.pop_front();
                check_field("head_valid", 32'(head_due.head_valid), 32'(o_out_item.head_valid));
                check_field("head_id", 32'(head_due.head_id), 32'(o_out_item.head_id));
                check_field("head_handle", head_due.head_handle, o_out_item.head_handle);
                check_field("head_level", 32'(head_due.head_level), 32'(o_out_item.head_level));
                check_field("entry_count", 32'(head_due.entry_count),
                            32'(o_out_item.entry_count));
                check_field("status", 32'(head_due.status), 32'(o_out_item.status));
            end
            sink_wait = sink_idle ? $urandom_range(0, 5) : 0;
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
